// ----- rtl/spg_pkg.sv -----
// ----------------------------------------------------------------------------
// spg_pkg
// Shared constants, codes and controller/datapath types of the three-axis
// step/direction pulse generator.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned CLOCK_HZ    = 2500000;
  localparam int unsigned NUM_MOTORS  = 3;
  localparam int unsigned MOTOR_SLOTS = 3;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned SEL_W   = 2;
  localparam int unsigned FREQ_W  = 16;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned PHT_W   = 8;
  localparam int unsigned TW      = 20;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDATA_W = 16;

  // quotient width of CLOCK_HZ / frequency and the divider step count width
  localparam int unsigned QW = $clog2(CLOCK_HZ + 1);
  localparam int unsigned CW = $clog2(QW + 1);
  localparam int unsigned SW = (QW > TW) ? QW : TW;

  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRIVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_PULSE_HIGH = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FREQ_MIN   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_FREQ_MAX   = 2'd2;

  localparam logic [PHT_W-1:0]  PHT_RESET      = 8'd50;
  localparam logic [FREQ_W-1:0] FREQ_MIN_RESET = 16'd4;
  localparam logic [FREQ_W-1:0] FREQ_MAX_RESET = 16'd10000;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic exec;
  } spg_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic item_ok;
    logic div_done;
    logic out_free;
  } spg_status_t;

endpackage

// ----- rtl/spg_if.sv -----
// ----------------------------------------------------------------------------
// spg channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spg_req_if;
  import spg_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [SEL_W-1:0]   motor_sel;
  logic [FREQ_W-1:0]  frequency;
  logic [STEPS_W-1:0] steps;
  logic               direction;

  modport source (output valid, req_type, motor_sel, frequency, steps, direction,
                  input ready);
  modport sink   (input valid, req_type, motor_sel, frequency, steps, direction,
                  output ready);
endinterface

interface spg_rsp_if;
  import spg_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [MOTOR_SLOTS-1:0] step_lines;
  logic [MOTOR_SLOTS-1:0] dir_lines;
  logic [MOTOR_SLOTS-1:0] busy_mask;
  logic                   any_busy;
  logic                   accepted;

  modport source (output valid, step_lines, dir_lines, busy_mask, any_busy, accepted,
                  input ready);
  modport sink   (input valid, step_lines, dir_lines, busy_mask, any_busy, accepted,
                  output ready);
endinterface

interface spg_cfg_if;
  import spg_pkg::*;
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/stepper_pulse_generator_3axis.sv -----
// ----------------------------------------------------------------------------
// stepper_pulse_generator_3axis
// Three-axis step/direction pulse generator with valid/ready channels.
// ----------------------------------------------------------------------------
// one item at a time: a tick, stop or rejected drive goes from acceptance in
// S_IDLE to S_EXEC, which registers its result once the result register is free
// an accepted drive passes through S_DIV, where the bit-serial divider forms
// CLOCK_HZ / frequency, before S_EXEC registers its result
// the next item is taken while the result register still waits on its sink
// synchronous reset clears all motor state and loads the register defaults
module stepper_pulse_generator_3axis (
  input logic       clk,
  input logic       rst,
  spg_req_if.sink   req,
  spg_rsp_if.source rsp,
  spg_cfg_if.sink   cfg
);
  import spg_pkg::*;

  spg_cmd_t    cmd;
  spg_status_t status;

  spg_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  spg_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

// ----- rtl/spg_div.sv -----
// ----------------------------------------------------------------------------
// spg_div
// Restoring divider, one quotient bit per cycle: CLOCK_HZ / divisor.
// ----------------------------------------------------------------------------
module spg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [spg_pkg::FREQ_W-1:0]  divisor,
  output logic                        done,
  output logic [spg_pkg::QW-1:0]      quotient
);
  import spg_pkg::*;

  logic              run;
  logic [CW-1:0]     cnt;
  logic [QW-1:0]     work;
  logic [FREQ_W-1:0] rem;
  logic [FREQ_W-1:0] dvs;
  logic [FREQ_W:0]   trial;
  logic [FREQ_W:0]   diff;
  logic              fits;
  logic [FREQ_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, work[QW-1]};
    diff     = trial - {1'b0, dvs};
    fits     = (trial >= {1'b0, dvs});
    rem_next = fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run && (cnt != CW'(QW))) begin
      cnt <= cnt + 1'b1;
    end
  end

  // work shifts dividend bits out at the top and quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= QW'(CLOCK_HZ);
      rem  <= '0;
      dvs  <= divisor;
    end else if (run && (cnt != CW'(QW))) begin
      work <= {work[QW-2:0], fits};
      rem  <= rem_next;
    end
  end

  assign done     = run && (cnt == CW'(QW));
  assign quotient = work;

endmodule

// ----- rtl/spg_ctrl.sv -----
// ----------------------------------------------------------------------------
// spg_ctrl
// Item sequencer: accept, optional low-time division, state update.
// ----------------------------------------------------------------------------
module spg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  spg_pkg::spg_status_t status,
  output spg_pkg::spg_cmd_t    cmd
);
  import spg_pkg::*;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd.in_ready  = 1'b0;
    cmd.div_start = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.item_valid) begin
          if (status.item_ok) begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register can take the new item
        if (status.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/spg_dp.sv -----
// ----------------------------------------------------------------------------
// spg_dp
// Datapath: config registers, per-motor pulse state, item and result registers.
// ----------------------------------------------------------------------------
module spg_dp (
  input  logic                 clk,
  input  logic                 rst,
  spg_req_if.sink              req,
  spg_rsp_if.source            rsp,
  spg_cfg_if.sink              cfg,
  input  spg_pkg::spg_cmd_t    cmd,
  output spg_pkg::spg_status_t status
);
  import spg_pkg::*;

  // configuration
  logic [PHT_W-1:0]  pulse_high_ticks;
  logic [FREQ_W-1:0] freq_min;
  logic [FREQ_W-1:0] freq_max;

  // latched item
  logic [REQ_W-1:0]   item_type;
  logic [SEL_W-1:0]   item_sel;
  logic [STEPS_W-1:0] item_steps;
  logic               item_dir;
  logic               item_ok;

  // motor state
  logic [MOTOR_SLOTS-1:0] step_level, step_level_next;
  logic [MOTOR_SLOTS-1:0] dir_level, dir_level_next;
  logic [MOTOR_SLOTS-1:0] motor_busy, motor_busy_next;
  logic [STEPS_W-1:0]     steps_left [MOTOR_SLOTS];
  logic [STEPS_W-1:0]     steps_left_next [MOTOR_SLOTS];
  logic [TW-1:0]          low_time [MOTOR_SLOTS];
  logic [TW-1:0]          low_time_next [MOTOR_SLOTS];
  logic [TW-1:0]          countdown [MOTOR_SLOTS];
  logic [TW-1:0]          countdown_next [MOTOR_SLOTS];

  // result register
  logic out_valid;

  logic              accept;
  logic              in_sel_ok;
  logic [SEL_W+1:0]  busy_ext;
  logic              in_ok;
  logic              div_done;
  logic [QW-1:0]     quotient;
  logic [SW-1:0]     q_ext;
  logic [SW-1:0]     pht_ext;
  logic [SW-1:0]     q_diff;
  logic [TW-1:0]     lt;
  logic [TW-1:0]     high_ticks;
  logic              item_sel_ok;
  logic [STEPS_W-1:0] steps_dec;

  assign accept = cmd.in_ready && req.valid;
  assign req.ready = cmd.in_ready;
  assign cfg.ready = 1'b1;

  // drive acceptance check on the incoming payload
  always_comb begin
    busy_ext  = '0;
    busy_ext[MOTOR_SLOTS-1:0] = motor_busy;
    in_sel_ok = (32'(req.motor_sel) < NUM_MOTORS);
    in_ok     = (req.req_type == REQ_DRIVE) && in_sel_ok &&
                !busy_ext[req.motor_sel] &&
                (req.frequency != '0) && (req.steps != '0) &&
                (req.frequency >= freq_min) && (req.frequency <= freq_max);
  end

  spg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .divisor  (req.frequency),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    status.item_valid = req.valid;
    status.item_ok    = in_ok;
    status.div_done   = div_done;
    status.out_free   = !out_valid || rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_high_ticks <= PHT_RESET;
      freq_min         <= FREQ_MIN_RESET;
      freq_max         <= FREQ_MAX_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PULSE_HIGH: pulse_high_ticks <= cfg.data[PHT_W-1:0];
        CFG_FREQ_MIN:   freq_min         <= cfg.data;
        CFG_FREQ_MAX:   freq_max         <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_type  <= req.req_type;
      item_sel   <= req.motor_sel;
      item_steps <= req.steps;
      item_dir   <= req.direction;
      item_ok    <= in_ok;
    end
  end

  // low time = max(1, period - high ticks), saturated
  always_comb begin
    q_ext   = SW'(quotient);
    pht_ext = SW'(pulse_high_ticks);
    q_diff  = q_ext - pht_ext;
    if (q_ext <= pht_ext) begin
      lt = TW'(1);
    end else if (q_diff > SW'(TIME_MAX)) begin
      lt = TIME_MAX;
    end else begin
      lt = q_diff[TW-1:0];
    end
    high_ticks  = (pulse_high_ticks == '0) ? TW'(1) : TW'(pulse_high_ticks);
    item_sel_ok = (32'(item_sel) < NUM_MOTORS);
  end

  always_comb begin
    step_level_next = step_level;
    dir_level_next  = dir_level;
    motor_busy_next = motor_busy;
    steps_left_next = steps_left;
    low_time_next   = low_time;
    countdown_next  = countdown;
    steps_dec       = '0;
    case (item_type)
      REQ_TICK: begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
          steps_dec = (steps_left[m] != '0) ? steps_left[m] - 1'b1 : steps_left[m];
          if (!motor_busy[m]) begin
            step_level_next[m] = 1'b0;
          end else if (countdown[m] > TW'(1)) begin
            countdown_next[m] = countdown[m] - 1'b1;
          end else if (!step_level[m]) begin
            step_level_next[m] = 1'b1;
            countdown_next[m]  = high_ticks;
          end else begin
            // falling edge uses up one step
            step_level_next[m] = 1'b0;
            steps_left_next[m] = steps_dec;
            if (steps_dec == '0) begin
              motor_busy_next[m] = 1'b0;
              countdown_next[m]  = '0;
            end else begin
              countdown_next[m] = low_time[m];
            end
          end
        end
      end
      REQ_DRIVE: begin
        if (item_ok) begin
          dir_level_next[item_sel]  = item_dir;
          motor_busy_next[item_sel] = 1'b1;
          step_level_next[item_sel] = 1'b0;
          steps_left_next[item_sel] = item_steps;
          low_time_next[item_sel]   = lt;
          countdown_next[item_sel]  = TW'(1);
        end
      end
      REQ_STOP: begin
        if (item_sel_ok) begin
          motor_busy_next[item_sel] = 1'b0;
          steps_left_next[item_sel] = '0;
          step_level_next[item_sel] = 1'b0;
          countdown_next[item_sel]  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_level <= '0;
      dir_level  <= '0;
      motor_busy <= '0;
      for (int m = 0; m < MOTOR_SLOTS; m++) begin
        steps_left[m] <= '0;
        low_time[m]   <= '0;
        countdown[m]  <= '0;
      end
    end else if (cmd.exec) begin
      step_level <= step_level_next;
      dir_level  <= dir_level_next;
      motor_busy <= motor_busy_next;
      steps_left <= steps_left_next;
      low_time   <= low_time_next;
      countdown  <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp.step_lines <= step_level_next;
      rsp.dir_lines  <= dir_level_next;
      rsp.busy_mask  <= motor_busy_next;
      rsp.any_busy   <= |motor_busy_next;
      rsp.accepted   <= (item_type == REQ_DRIVE) && item_ok;
    end
  end

  assign rsp.valid = out_valid;

endmodule
